FILE: rtl/mctp_pkg.sv
package mctp_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN_ERR = 2'd1,
    ST_VAL_ERR = 2'd2,
    ST_RX_ERR  = 2'd3
  } mctp_status_t;

  // Token kinds
  typedef enum logic [2:0] {
    KIND_HEX     = 3'd0,
    KIND_OFFSET  = 3'd1,
    KIND_SEGMENT = 3'd2,
    KIND_COUNT   = 3'd3,
    KIND_UNKNOWN = 3'd4
  } mctp_kind_t;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam int unsigned HEX_LEN_MAX = 4;

  // Item handed from the tokeniser to the command stage
  typedef struct packed {
    logic        rx_err;
    logic [7:0]  lead;
    logic [4:0]  len;
    logic        hex_len_ok;
    logic        len_one;
    logic [15:0] accum;
    logic        bad;
  } mctp_event_t;

  // Result item
  typedef struct packed {
    mctp_status_t status;
    mctp_kind_t   kind;
    logic         done_res;
    logic [7:0]   first_char;
    logic [4:0]   token_length;
    logic [15:0]  value;
    logic [15:0]  offset;
    logic [15:0]  segment;
    logic [15:0]  count;
  } mctp_result_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h20;
    return r;
  endfunction

  // Bit 4 set means not a hex digit
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

FILE: rtl/mctp_fifo.sv
module mctp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW:0] FULL_CNT = (AW + 1)'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == FULL_CNT);
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (do_rd && !do_wr) fill <= fill - 1'b1;
    end
  end

endmodule

FILE: rtl/mctp_front.sv
module mctp_front import mctp_pkg::*; #(
  parameter int unsigned TOKEN_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  ch,
  input  logic        rx_error,
  input  logic        ev_full,
  output logic        ev_push,
  output mctp_event_t ev
);

  localparam int unsigned CW = $clog2(TOKEN_MAX + 2);
  localparam logic [CW-1:0] CNT_MAX = CW'(TOKEN_MAX);
  localparam logic [CW-1:0] CNT_HEX = CW'(HEX_LEN_MAX);

  logic          in_token;
  logic [CW-1:0] char_count;
  logic [7:0]    lead_char;
  logic [15:0]   hex_accum;
  logic          bad_digit_seen;

  logic          in_token_next;
  logic [CW-1:0] char_count_next;
  logic [7:0]    lead_char_next;
  logic [15:0]   hex_accum_next;
  logic          bad_digit_seen_next;

  logic          accept;
  logic          is_sep;
  logic [7:0]    up;
  logic [4:0]    dig;
  logic [CW-1:0] base_cnt;
  logic [7:0]    base_lead;
  logic [15:0]   base_acc;
  logic          base_bad;
  logic [CW-1:0] fin_cnt;

  assign accept = push && !ev_full;
  assign is_sep = (ch <= CHAR_SPACE) || (ch >= CHAR_DEL);
  assign up     = to_upper(ch);
  assign dig    = digit_of(up);

  // Classify the character and build the token state
  always_comb begin
    base_cnt  = in_token ? char_count : '0;
    base_lead = in_token ? lead_char : up;
    base_acc  = in_token ? hex_accum : '0;
    base_bad  = in_token ? bad_digit_seen : 1'b0;

    in_token_next       = in_token;
    char_count_next     = char_count;
    lead_char_next      = lead_char;
    hex_accum_next      = hex_accum;
    bad_digit_seen_next = bad_digit_seen;
    ev_push             = 1'b0;
    fin_cnt             = char_count;

    ev.rx_err = 1'b0;
    ev.lead   = lead_char;
    ev.accum  = hex_accum;
    ev.bad    = bad_digit_seen;

    if (accept) begin
      if (rx_error) begin
        // Abort any partial token
        ev_push       = 1'b1;
        ev.rx_err     = 1'b1;
        ev.lead       = in_token ? lead_char : 8'h00;
        fin_cnt       = in_token ? char_count : '0;
        in_token_next = 1'b0;
      end else if (is_sep) begin
        // Close an open token, skip otherwise
        ev_push       = in_token;
        in_token_next = 1'b0;
      end else begin
        char_count_next = base_cnt + 1'b1;
        lead_char_next  = base_lead;
        if (char_count_next > CNT_MAX) begin
          // Overflowing character ends the token
          ev_push       = 1'b1;
          ev.lead       = base_lead;
          ev.accum      = base_acc;
          ev.bad        = base_bad;
          fin_cnt       = char_count_next;
          in_token_next = 1'b0;
        end else begin
          in_token_next       = 1'b1;
          hex_accum_next      = base_acc;
          bad_digit_seen_next = base_bad;
          if (!base_bad) begin
            if (dig[4]) begin
              hex_accum_next      = {base_acc[11:0], 4'h0};
              bad_digit_seen_next = 1'b1;
            end else begin
              hex_accum_next = {base_acc[11:0], dig[3:0]};
            end
          end
        end
      end
    end

    ev.len        = 5'(fin_cnt);
    ev.hex_len_ok = (fin_cnt != '0) && (fin_cnt <= CNT_HEX);
    ev.len_one    = (fin_cnt == CW'(1));
  end

  // Hold token state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_token       <= 1'b0;
      char_count     <= '0;
      lead_char      <= '0;
      hex_accum      <= '0;
      bad_digit_seen <= 1'b0;
    end else begin
      in_token       <= in_token_next;
      char_count     <= char_count_next;
      lead_char      <= lead_char_next;
      hex_accum      <= hex_accum_next;
      bad_digit_seen <= bad_digit_seen_next;
    end
  end

endmodule

FILE: rtl/mctp_back.sv
module mctp_back import mctp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         ev_empty,
  input  mctp_event_t  ev,
  output logic         ev_pop,
  input  logic         res_full,
  output logic         res_push,
  output mctp_result_t res
);

  logic [15:0] last_value;
  logic [15:0] offset_reg;
  logic [15:0] segment_reg;
  logic [15:0] count_reg;

  logic [15:0] last_value_next;
  logic [15:0] offset_reg_next;
  logic [15:0] segment_reg_next;
  logic [15:0] count_reg_next;

  logic         take;
  logic         lead_hex;
  logic         lead_letter;
  mctp_status_t st;
  mctp_kind_t   kd;
  logic         dn;

  assign take     = !ev_empty && !res_full;
  assign ev_pop   = take;
  assign res_push = take;
  assign lead_hex = (digit_of(ev.lead) <= 5'h0F);
  assign lead_letter = (ev.lead == CHAR_O) || (ev.lead == CHAR_S) || (ev.lead == CHAR_L);

  // Carry out the command
  always_comb begin
    last_value_next  = last_value;
    offset_reg_next  = offset_reg;
    segment_reg_next = segment_reg;
    count_reg_next   = count_reg;
    st = ST_OK;
    kd = KIND_HEX;
    dn = 1'b0;

    if (ev.rx_err) begin
      st = ST_RX_ERR;
    end else if (lead_hex) begin
      dn = 1'b1;
      if (!ev.hex_len_ok) begin
        st              = ST_LEN_ERR;
        last_value_next = '0;
      end else begin
        st              = ev.bad ? ST_VAL_ERR : ST_OK;
        last_value_next = ev.accum;
      end
    end else if (lead_letter) begin
      kd = (ev.lead == CHAR_O) ? KIND_OFFSET :
           (ev.lead == CHAR_S) ? KIND_SEGMENT : KIND_COUNT;
      if (!ev.len_one) begin
        st = ST_LEN_ERR;
      end else begin
        dn = 1'b1;
        unique case (kd)
          KIND_OFFSET:  offset_reg_next  = last_value;
          KIND_SEGMENT: segment_reg_next = last_value;
          default:      count_reg_next   = last_value;
        endcase
      end
    end else begin
      kd = KIND_UNKNOWN;
    end

    res.status       = st;
    res.kind         = kd;
    res.done_res     = dn;
    res.first_char   = ev.lead;
    res.token_length = ev.len;
    res.value        = last_value_next;
    res.offset       = offset_reg_next;
    res.segment      = segment_reg_next;
    res.count        = count_reg_next;
  end

  // Hold the monitor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_value  <= '0;
      offset_reg  <= '0;
      segment_reg <= '0;
      count_reg   <= '0;
    end else if (take) begin
      last_value  <= last_value_next;
      offset_reg  <= offset_reg_next;
      segment_reg <= segment_reg_next;
      count_reg   <= count_reg_next;
    end
  end

`ifndef SYNTHESIS
  a_offset_only_on_set: assert property (@(posedge clk) disable iff (rst)
    !(take && !ev.rx_err && ev.lead == CHAR_O && ev.len_one) |=> $stable(offset_reg))
    else $error("offset changed without a set-offset item");

  a_segment_only_on_set: assert property (@(posedge clk) disable iff (rst)
    !(take && !ev.rx_err && ev.lead == CHAR_S && ev.len_one) |=> $stable(segment_reg))
    else $error("segment changed without a set-segment item");

  a_count_only_on_set: assert property (@(posedge clk) disable iff (rst)
    !(take && !ev.rx_err && ev.lead == CHAR_L && ev.len_one) |=> $stable(count_reg))
    else $error("count changed without a set-count item");

  a_value_only_on_hex: assert property (@(posedge clk) disable iff (rst)
    !(take && !ev.rx_err && lead_hex) |=> $stable(last_value))
    else $error("value changed without a hex item");
`endif

endmodule

FILE: rtl/monitor_command_token_parser_top.sv
// A result reaches the result ports once the item ending its token has been written to the
// event queue and then to the result queue. One item per cycle is taken while full is low,
// with a two-entry queue between tokeniser and command stage and one on the result side.
// Separators outside a token and characters inside a token within TOKEN_MAX give no result.
// Reset (synchronous, active high) clears token state, monitor registers and both queues.
module monitor_command_token_parser_top import mctp_pkg::*; #(
  parameter int unsigned TOKEN_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch,
  input  logic        rx_error,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [2:0]  kind,
  output logic        done_res,
  output logic [7:0]  first_char,
  output logic [4:0]  token_length,
  output logic [15:0] value,
  output logic [15:0] offset,
  output logic [15:0] segment,
  output logic [15:0] count
);

  localparam int unsigned EV_W  = $bits(mctp_event_t);
  localparam int unsigned RES_W = $bits(mctp_result_t);

  logic         ev_push;
  logic         ev_full;
  logic         ev_empty;
  logic         ev_pop;
  mctp_event_t  ev_in;
  mctp_event_t  ev_out;
  logic         res_push;
  logic         res_full;
  mctp_result_t res_in;
  mctp_result_t res_out;

  assign full = ev_full;

  // Tokeniser
  mctp_front #(.TOKEN_MAX(TOKEN_MAX)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .ch       (ch),
    .rx_error (rx_error),
    .ev_full  (ev_full),
    .ev_push  (ev_push),
    .ev       (ev_in)
  );

  // Queue between tokeniser and command stage
  mctp_fifo #(.WIDTH(EV_W), .DEPTH(2)) u_ev_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ev_push),
    .wr_data (ev_in),
    .full    (ev_full),
    .rd_en   (ev_pop),
    .rd_data (ev_out),
    .empty   (ev_empty)
  );

  // Command stage
  mctp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ev_empty (ev_empty),
    .ev       (ev_out),
    .ev_pop   (ev_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // Result queue
  mctp_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign status       = res_out.status;
  assign kind         = res_out.kind;
  assign done_res     = res_out.done_res;
  assign first_char   = res_out.first_char;
  assign token_length = res_out.token_length;
  assign value        = res_out.value;
  assign offset       = res_out.offset;
  assign segment      = res_out.segment;
  assign count        = res_out.count;

endmodule
